// File: hdl/tlc_pkg.sv
package tlc_pkg;

    localparam int WORD_W = 32;
    localparam int DIM_W = 13;
    localparam int IDX_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam int DEFAULT_MAX_DIM = 4096;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNELS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd4;

    localparam logic DIR_HWCK_TO_KCHW = 1'b0;
    localparam logic DIR_KCHW_TO_HWCK = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] channels;
        logic [DIM_W-1:0] kernels;
        logic             direction;
    } t_geom;

endpackage

// File: hdl/tlc_fifo.sv
module tlc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CNTW-1:0]  r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CNTW-1:0]  n_count;

    assign o_empty = (r_count == '0);
    assign o_full = (r_count == CNTW'(DEPTH));
    assign o_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTH
    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("queue count did not follow a lone push");
`endif

endmodule

// File: hdl/tlc_front.sv
module tlc_front
    import tlc_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM,
    parameter int CW = $clog2(MAX_DIM),
    parameter int ENTRY_W = WORD_W + 1 + 4 * CW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic [WORD_W-1:0]    i_in_word,
    input  logic                 i_fifo_full,
    output logic                 o_in_ready,
    output logic                 o_push,
    output logic [ENTRY_W-1:0]   o_entry,
    output t_geom                o_geom
);

    localparam int CMPW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_channels;
    logic [DIM_W-1:0] r_kernels;
    logic             r_direction;
    logic [CW-1:0]    r_outer;
    logic [CW-1:0]    r_second;
    logic [CW-1:0]    r_third;
    logic [CW-1:0]    r_inner;
    logic [CW-1:0]    n_outer;
    logic [CW-1:0]    n_second;
    logic [CW-1:0]    n_third;
    logic [CW-1:0]    n_inner;
    logic [DIM_W-1:0] l0;
    logic [DIM_W-1:0] l1;
    logic [DIM_W-1:0] l2;
    logic [DIM_W-1:0] l3;
    logic             w0;
    logic             w1;
    logic             w2;
    logic             w3;
    logic             cfg_hit;
    logic [CW-1:0]    x1;
    logic [CW-1:0]    y1;
    logic [CW-1:0]    y2;
    logic [CW-1:0]    y3;
    t_geom            geom;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [31:0] v;
        v = 32'(d);
        if (v == 32'd0) begin
            v = 32'd1;
        end else if (v > 32'(MAX_DIM)) begin
            v = 32'(MAX_DIM);
        end
        return v[DIM_W-1:0];
    endfunction

    always_comb begin
        geom.height = eff_dim(r_height);
        geom.width = eff_dim(r_width);
        geom.channels = eff_dim(r_channels);
        geom.kernels = eff_dim(r_kernels);
        geom.direction = r_direction;
    end

    assign o_geom = geom;
    assign o_in_ready = !i_fifo_full;
    assign o_push = i_in_valid && o_in_ready;

    always_comb begin
        unique case (r_direction)
            DIR_HWCK_TO_KCHW: begin
                l0 = geom.height;
                l1 = geom.width;
                l2 = geom.channels;
                l3 = geom.kernels;
                x1 = r_inner;
                y1 = r_third;
                y2 = r_outer;
                y3 = r_second;
            end
            default: begin
                l0 = geom.kernels;
                l1 = geom.channels;
                l2 = geom.height;
                l3 = geom.width;
                x1 = r_third;
                y1 = r_inner;
                y2 = r_second;
                y3 = r_outer;
            end
        endcase
    end

    always_comb begin
        w3 = (CMPW'(r_inner) + CMPW'(1)) >= CMPW'(l3);
        w2 = w3 && ((CMPW'(r_third) + CMPW'(1)) >= CMPW'(l2));
        w1 = w2 && ((CMPW'(r_second) + CMPW'(1)) >= CMPW'(l1));
        w0 = w1 && ((CMPW'(r_outer) + CMPW'(1)) >= CMPW'(l0));
        n_inner = w3 ? '0 : r_inner + CW'(1);
        n_third = w3 ? (w2 ? '0 : r_third + CW'(1)) : r_third;
        n_second = w2 ? (w1 ? '0 : r_second + CW'(1)) : r_second;
        n_outer = w1 ? (w0 ? '0 : r_outer + CW'(1)) : r_outer;
    end

    assign o_entry = {i_in_word, w0, x1, y1, y2, y3};

    always_comb begin
        unique case (i_cfg_index)
            REG_HEIGHT, REG_WIDTH, REG_CHANNELS, REG_KERNELS, REG_DIRECTION: begin
                cfg_hit = i_cfg_wr_en;
            end
            default: begin
                cfg_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= DIM_W'(1);
            r_width <= DIM_W'(1);
            r_channels <= DIM_W'(1);
            r_kernels <= DIM_W'(1);
            r_direction <= DIR_HWCK_TO_KCHW;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                REG_WIDTH: begin
                    r_width <= i_cfg_data;
                end
                REG_CHANNELS: begin
                    r_channels <= i_cfg_data;
                end
                REG_KERNELS: begin
                    r_kernels <= i_cfg_data;
                end
                REG_DIRECTION: begin
                    r_direction <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer <= '0;
            r_second <= '0;
            r_third <= '0;
            r_inner <= '0;
        end else if (cfg_hit) begin
            r_outer <= '0;
            r_second <= '0;
            r_third <= '0;
            r_inner <= '0;
        end else if (o_push) begin
            r_outer <= n_outer;
            r_second <= n_second;
            r_third <= n_third;
            r_inner <= n_inner;
        end
    end

`ifndef SYNTH
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && w0) |=> (r_outer == '0 && r_second == '0 && r_third == '0
            && r_inner == '0))
        else $error("counters did not return to zero after the last word");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_outer == '0 && r_second == '0 && r_third == '0
            && r_inner == '0))
        else $error("counters not cleared by a register write");
`endif

endmodule

// File: hdl/tlc_back.sv
module tlc_back
    import tlc_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM,
    parameter int CW = $clog2(MAX_DIM),
    parameter int ENTRY_W = WORD_W + 1 + 4 * CW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_geom              i_geom,
    input  logic [ENTRY_W-1:0] i_entry,
    input  logic               i_fifo_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [WORD_W-1:0]  o_out_word,
    output logic [IDX_W-1:0]   o_dest_index,
    output logic               o_tensor_last
);

    localparam int T1W = CW + DIM_W + 1;
    localparam int T2W = T1W + DIM_W + 1;
    localparam int SPLIT = 24;
    localparam int HW = T2W - SPLIT;
    localparam int P1W = CW + DIM_W;
    localparam int P2W = T1W + DIM_W;
    localparam int PLW = SPLIT + DIM_W;
    localparam int PHW = HW + DIM_W;

    logic [WORD_W-1:0] e_word;
    logic              e_last;
    logic [CW-1:0]     e_x1;
    logic [CW-1:0]     e_y1;
    logic [CW-1:0]     e_y2;
    logic [CW-1:0]     e_y3;
    logic [DIM_W-1:0]  m1;
    logic [DIM_W-1:0]  m2;
    logic [DIM_W-1:0]  m3;
    logic              adv;
    logic [P1W-1:0]    prod1;
    logic [P2W-1:0]    prod2;
    logic [T1W-1:0]    n_t1;
    logic [T2W-1:0]    n_t2;
    logic [PLW-1:0]    n_p_lo;
    logic [PHW-1:0]    n_p_hi;
    logic [IDX_W-1:0]  n_dest;

    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic              r_v4;
    logic [WORD_W-1:0] r_word1;
    logic [WORD_W-1:0] r_word2;
    logic [WORD_W-1:0] r_word3;
    logic [WORD_W-1:0] r_word4;
    logic              r_last1;
    logic              r_last2;
    logic              r_last3;
    logic              r_last4;
    logic [T1W-1:0]    r_t1;
    logic [CW-1:0]     r_y2_1;
    logic [CW-1:0]     r_y3_1;
    logic [T2W-1:0]    r_t2;
    logic [CW-1:0]     r_y3_2;
    logic [PLW-1:0]    r_p_lo;
    logic [PHW-1:0]    r_p_hi;
    logic [CW-1:0]     r_y3_3;
    logic [IDX_W-1:0]  r_dest;

    assign {e_word, e_last, e_x1, e_y1, e_y2, e_y3} = i_entry;

    always_comb begin
        unique case (i_geom.direction)
            DIR_HWCK_TO_KCHW: begin
                m1 = i_geom.channels;
                m2 = i_geom.height;
                m3 = i_geom.width;
            end
            default: begin
                m1 = i_geom.width;
                m2 = i_geom.channels;
                m3 = i_geom.kernels;
            end
        endcase
    end

    assign adv = !r_v4 || i_out_ready;
    assign o_pop = adv && !i_fifo_empty;

    always_comb begin
        prod1 = P1W'(e_x1) * P1W'(m1);
        n_t1 = T1W'(prod1) + T1W'(e_y1);
        prod2 = P2W'(r_t1) * P2W'(m2);
        n_t2 = T2W'(prod2) + T2W'(r_y2_1);
        n_p_lo = PLW'(r_t2[SPLIT-1:0]) * PLW'(m3);
        n_p_hi = PHW'(r_t2[T2W-1:SPLIT]) * PHW'(m3);
        n_dest = (IDX_W'(r_p_hi) << SPLIT) + IDX_W'(r_p_lo) + IDX_W'(r_y3_3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= !i_fifo_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_word1 <= e_word;
            r_last1 <= e_last;
            r_t1 <= n_t1;
            r_y2_1 <= e_y2;
            r_y3_1 <= e_y3;
            r_word2 <= r_word1;
            r_last2 <= r_last1;
            r_t2 <= n_t2;
            r_y3_2 <= r_y3_1;
            r_word3 <= r_word2;
            r_last3 <= r_last2;
            r_p_lo <= n_p_lo;
            r_p_hi <= n_p_hi;
            r_y3_3 <= r_y3_2;
            r_word4 <= r_word3;
            r_last4 <= r_last3;
            r_dest <= n_dest;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_word = r_word4;
    assign o_dest_index = r_dest;
    assign o_tensor_last = r_last4;

`ifndef SYNTH
    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_out_ready) |-> !o_pop)
        else $error("queue popped while the output word was stalled");
`endif

endmodule

// File: hdl/tensor_layout_hwck_kchw_converter_top.sv
// Weight layout converter between HWCK and KCHW. Words enter in source order and leave
// unchanged with their element index in the destination layout and a flag on the last
// word of the tensor. Program the four dimensions and the direction while the block is
// idle; any write to a defined register restarts the tensor at its first word. The block
// takes one word per clock while its queue has room and delivers one per clock while the
// output is ready. A word passes through the four-entry queue behind the dimension
// counters, then the index pipeline, where three stages of narrow multiplies are
// followed by a final add that lands in the output register.
module tensor_layout_hwck_kchw_converter_top
    import tlc_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [WORD_W-1:0]    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_W-1:0]    o_out_word,
    output logic [IDX_W-1:0]     o_dest_index,
    output logic                 o_tensor_last
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int ENTRY_W = WORD_W + 1 + 4 * CW;

    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;
    logic [ENTRY_W-1:0] push_entry;
    logic [ENTRY_W-1:0] pop_entry;
    t_geom              geom;

    tlc_front #(
        .MAX_DIM(MAX_DIM),
        .CW(CW),
        .ENTRY_W(ENTRY_W)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .i_in_word(i_in_word),
        .i_fifo_full(fifo_full),
        .o_in_ready(o_in_ready),
        .o_push(push),
        .o_entry(push_entry),
        .o_geom(geom)
    );

    tlc_fifo #(
        .WIDTH(ENTRY_W),
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_data(push_entry),
        .i_pop(pop),
        .o_data(pop_entry),
        .o_empty(fifo_empty),
        .o_full(fifo_full)
    );

    tlc_back #(
        .MAX_DIM(MAX_DIM),
        .CW(CW),
        .ENTRY_W(ENTRY_W)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_geom(geom),
        .i_entry(pop_entry),
        .i_fifo_empty(fifo_empty),
        .o_pop(pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word(o_out_word),
        .o_dest_index(o_dest_index),
        .o_tensor_last(o_tensor_last)
    );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tlc_pkg::*;

    localparam int MAX_DIM = DEFAULT_MAX_DIM;
    localparam int CTR_W = $clog2(MAX_DIM);
    localparam int ITEMS = 1450;
    localparam int QUIET_TAIL = 150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  index;
        logic              last;
    } t_dest_word;

    typedef enum logic {ROW_CFG, ROW_WORD} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DIM_W-1:0]     data;
        logic [WORD_W-1:0]    word;
        bit                   typed;
        logic [IDX_W-1:0]     want_index;
        logic                 want_last;
    } t_script_row;

    localparam int SCRIPT_LEN = 31;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [WORD_W-1:0]    i_in_word;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [WORD_W-1:0]    o_out_word;
    logic [IDX_W-1:0]     o_dest_index;
    logic                 o_tensor_last;

    t_geom            geom;
    logic [CTR_W-1:0] ctr_outer;
    logic [CTR_W-1:0] ctr_second;
    logic [CTR_W-1:0] ctr_third;
    logic [CTR_W-1:0] ctr_inner;

    t_dest_word pending_words[$];
    int         mismatches;
    int         words_sent;
    int         words_checked;
    int         tensors_closed;
    int         settings_seen;
    int         cycles;
    int         gap_pct;
    int         stall_pct;
    bit         quiet;

    // Words 6 to 11 walk a small HWCK tensor, 13 to 19 a KCHW one across a write to an
    // unmapped register, and the last rows reach into the top index bits.
    t_script_row script [SCRIPT_LEN] = '{
        '{ROW_WORD, '0, '0, 32'h0000_0000, 1'b1, 48'd0, 1'b1},
        '{ROW_WORD, '0, '0, 32'hFFFF_FFFF, 1'b1, 48'd0, 1'b1},
        '{ROW_CFG, REG_HEIGHT, 13'd2, '0, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'hA5A5_A5A5, 1'b1, 48'd0, 1'b0},
        '{ROW_WORD, '0, '0, 32'h5A5A_5A5A, 1'b1, 48'd1, 1'b1},
        '{ROW_CFG, REG_KERNELS, 13'd3, '0, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'h0000_0001, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'h8000_0000, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'h1234_5678, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'h8765_4321, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'h7FFF_FFFF, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'hFFFF_0000, 1'b0, '0, 1'b0},
        '{ROW_CFG, REG_DIRECTION, {12'd0, DIR_KCHW_TO_HWCK}, '0, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'h0F0F_0F0F, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'hF0F0_F0F0, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'h3333_3333, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'hCCCC_CCCC, 1'b0, '0, 1'b0},
        '{ROW_CFG, REG_UNMAPPED, 13'h1FFF, '0, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'h5555_5555, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'hAAAA_AAAA, 1'b0, '0, 1'b0},
        '{ROW_CFG, REG_WIDTH, 13'd0, '0, 1'b0, '0, 1'b0},
        '{ROW_CFG, REG_CHANNELS, 13'h1FFF, '0, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'hDEAD_BEEF, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'hCAFE_F00D, 1'b0, '0, 1'b0},
        '{ROW_CFG, REG_DIRECTION, {12'hFFF, DIR_HWCK_TO_KCHW}, '0, 1'b0, '0, 1'b0},
        '{ROW_CFG, REG_HEIGHT, 13'd4096, '0, 1'b0, '0, 1'b0},
        '{ROW_CFG, REG_WIDTH, 13'h1FFF, '0, 1'b0, '0, 1'b0},
        '{ROW_CFG, REG_KERNELS, 13'd4096, '0, 1'b0, '0, 1'b0},
        '{ROW_WORD, '0, '0, 32'h0000_FFFF, 1'b1, 48'd0, 1'b0},
        '{ROW_WORD, '0, '0, 32'hFFFF_FFFE, 1'b1, 48'h10_0000_0000, 1'b0},
        '{ROW_WORD, '0, '0, 32'h0000_0002, 1'b0, '0, 1'b0}
    };

    tensor_layout_hwck_kchw_converter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word),
        .o_dest_index  (o_dest_index),
        .o_tensor_last (o_tensor_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned eff_dim(input logic [DIM_W-1:0] d);
        if (d == '0) begin
            return 64'd1;
        end
        if (d > MAX_DIM) begin
            return 64'(MAX_DIM);
        end
        return 64'(d);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DIM_W-1:0] data);
        case (idx)
            REG_HEIGHT: begin
                geom.height = data;
            end
            REG_WIDTH: begin
                geom.width = data;
            end
            REG_CHANNELS: begin
                geom.channels = data;
            end
            REG_KERNELS: begin
                geom.kernels = data;
            end
            REG_DIRECTION: begin
                geom.direction = data[0];
            end
            default: begin
                return;
            end
        endcase
        ctr_outer = '0;
        ctr_second = '0;
        ctr_third = '0;
        ctr_inner = '0;
    endfunction

    // Works out where the next source word lands and advances the counter nest.
    function automatic t_dest_word place_word(input logic [WORD_W-1:0] w);
        longint unsigned hh, ww, cc, kk;
        longint unsigned l0, l1, l2, l3;
        longint unsigned a, b, c, d, dest;
        bit w0, w1, w2, w3;
        t_dest_word r;
        hh = eff_dim(geom.height);
        ww = eff_dim(geom.width);
        cc = eff_dim(geom.channels);
        kk = eff_dim(geom.kernels);
        a = 64'(ctr_outer);
        b = 64'(ctr_second);
        c = 64'(ctr_third);
        d = 64'(ctr_inner);
        if (geom.direction == DIR_HWCK_TO_KCHW) begin
            l0 = hh;
            l1 = ww;
            l2 = cc;
            l3 = kk;
            dest = ((d * cc + c) * hh + a) * ww + b;
        end else begin
            l0 = kk;
            l1 = cc;
            l2 = hh;
            l3 = ww;
            dest = ((c * ww + d) * cc + b) * kk + a;
        end
        w3 = (d + 1) >= l3;
        w2 = w3 && ((c + 1) >= l2);
        w1 = w2 && ((b + 1) >= l1);
        w0 = w1 && ((a + 1) >= l0);
        r.word = w;
        r.index = dest[IDX_W-1:0];
        r.last = w0;
        ctr_inner = w3 ? '0 : CTR_W'(d + 1);
        if (w3) begin
            ctr_third = w2 ? '0 : CTR_W'(c + 1);
        end
        if (w2) begin
            ctr_second = w1 ? '0 : CTR_W'(b + 1);
        end
        if (w1) begin
            ctr_outer = w0 ? '0 : CTR_W'(a + 1);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s of output word %0d: got %0h, expected %0h",
                 field, words_checked, got, want);
        mismatches++;
    endtask

    task automatic push_word(input logic [WORD_W-1:0] w, input bit typed,
                             input t_dest_word want);
        t_dest_word predicted;
        t_dest_word expected;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = place_word(w);
        expected = typed ? want : predicted;
        pending_words = {pending_words, expected};
        words_sent++;
        quiet = words_sent >= ITEMS - QUIET_TAIL;
        if (!quiet && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_output
        t_dest_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("arrival (nothing pending)", 64'(o_dest_index), '0);
            end else begin
                want = pending_words.pop_front();
                if (o_out_word !== want.word) begin
                    report_mismatch("word", 64'(o_out_word), 64'(want.word));
                end
                if (o_dest_index !== want.index) begin
                    report_mismatch("destination index", 64'(o_dest_index),
                                    64'(want.index));
                end
                if (o_tensor_last !== want.last) begin
                    report_mismatch("tensor end flag", 64'(o_tensor_last),
                                    64'(want.last));
                end
            end
            if (o_tensor_last === 1'b1) begin
                tensors_closed++;
            end
            words_checked++;
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            if (!quiet && $urandom_range(99) < stall_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d words pending", cycles,
                 pending_words.size());
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_dest_word       none;
        longint unsigned  tensor_size;
        int               phase_len;
        int               roll;
        logic [DIM_W-1:0] dim;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        geom = '{height: 13'd1, width: 13'd1, channels: 13'd1, kernels: 13'd1,
                 direction: DIR_HWCK_TO_KCHW};
        ctr_outer = '0;
        ctr_second = '0;
        ctr_third = '0;
        ctr_inner = '0;
        none = '{'0, '0, 1'b0};
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        tensors_closed = 0;
        settings_seen = 1;
        gap_pct = 30;
        stall_pct = 30;
        quiet = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (script[i].kind == ROW_CFG) begin
                drain();
                cfg_write(script[i].idx, script[i].data);
                settings_seen++;
            end else begin
                push_word(script[i].word, script[i].typed,
                          '{script[i].word, script[i].want_index, script[i].want_last});
            end
        end

        while (words_sent < ITEMS) begin
            drain();
            settings_seen++;
            if ($urandom_range(99) < 15) begin
                // An unmapped register leaves the counters where they were.
                cfg_write(CFG_IDX_W'($urandom_range(REG_DIRECTION + 1, (1 << CFG_IDX_W) - 1)),
                          DIM_W'($urandom));
            end else begin
                for (int r = REG_HEIGHT; r <= REG_KERNELS; r++) begin
                    if ($urandom_range(99) < 70) begin
                        roll = $urandom_range(99);
                        if (roll < 8) begin
                            dim = '0;
                        end else if (roll < 13) begin
                            dim = DIM_W'(MAX_DIM);
                        end else if (roll < 18) begin
                            dim = DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
                        end else if (roll < 28) begin
                            dim = DIM_W'($urandom_range(6, 40));
                        end else begin
                            dim = DIM_W'($urandom_range(1, 5));
                        end
                        cfg_write(CFG_IDX_W'(r), dim);
                    end
                end
                cfg_write(REG_DIRECTION, DIM_W'($urandom));
            end
            gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
            stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
            tensor_size = eff_dim(geom.height) * eff_dim(geom.width)
                        * eff_dim(geom.channels) * eff_dim(geom.kernels);
            if (tensor_size <= 96) begin
                phase_len = int'(tensor_size) * $urandom_range(1, 3);
                if (tensor_size > 1 && $urandom_range(3) == 0) begin
                    phase_len -= $urandom_range(1, int'(tensor_size) - 1);
                end
            end else begin
                phase_len = $urandom_range(8, 48);
            end
            if (phase_len > ITEMS - words_sent) begin
                phase_len = ITEMS - words_sent;
            end
            for (int j = 0; j < phase_len; j++) begin
                push_word($urandom, 1'b0, none);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d words under %0d register settings, both directions,",
                 words_sent, settings_seen);
        $display("with %0d tensor ends and %0d mismatches", tensors_closed, mismatches);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
